FILE: sv/lmx_pkg.sv
// Shared types and constants for the Lamport mutual exclusion node.
package lmx_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int CLOCK_W     = 32;
    localparam int PROC_W      = 8;
    localparam int ENTRY_W     = CLOCK_W + PROC_W;

    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_NEEDED = 2'd1;

    // operation field codes
    localparam logic [2:0] OPC_RECV_REQ = 3'd0;
    localparam logic [2:0] OPC_RECV_ACK = 3'd1;
    localparam logic [2:0] OPC_RECV_REL = 3'd2;
    localparam logic [2:0] OPC_LOCAL    = 3'd3;
    localparam logic [2:0] OPC_TRY      = 3'd4;

    typedef enum logic [2:0] {
        OP_REQ,
        OP_ACK,
        OP_REL,
        OP_LOCAL,
        OP_TRY,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_REQ,
        KIND_ACK,
        KIND_REL
    } kind_t;

    typedef struct packed {
        op_t               op;
        logic [CLOCK_W-1:0] clock;
        logic [PROC_W-1:0]  process;
        logic [PROC_W-1:0]  target;
    } cmd_t;

    typedef struct packed {
        logic               busy;
        logic [Q_CNT_W-1:0] count;
    } bstat_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_INS_RD,
        B_INS_CMP,
        B_POP_RD,
        B_POP_WR,
        B_DONE
    } bstate_t;

endpackage

FILE: sv/lmx_ifs.sv
// Event and result channel interfaces.
interface lmx_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] msg_clock;
    logic [7:0]  msg_process;
    logic [7:0]  msg_target;

    modport source (output valid, operation, msg_clock, msg_process, msg_target,
                    input ready);
    modport sink   (input valid, operation, msg_clock, msg_process, msg_target,
                    output ready);
endinterface

interface lmx_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [31:0] out_clock;
    logic [7:0]  out_process;
    logic [7:0]  out_target;
    logic        granted;
    logic        dropped;
    logic [31:0] clock_now;

    modport source (output valid, out_kind, out_clock, out_process, out_target,
                    granted, dropped, clock_now, input ready);
    modport sink   (input valid, out_kind, out_clock, out_process, out_target,
                    granted, dropped, clock_now, output ready);
endinterface

FILE: sv/lmx_ram.sv
// Generic single write port RAM with registered read.
module lmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/lmx_front.sv
// Front end: accepts events, decodes the operation and queues commands.
module lmx_front (
    input  logic          clk,
    input  logic          rst_n,
    lmx_event_if.sink     events,
    output logic          cmd_valid,
    output lmx_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import lmx_pkg::*;

    cmd_t                  fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  push;
    cmd_t                  dec;

    always_comb
    begin
        dec.clock   = events.msg_clock;
        dec.process = events.msg_process;
        dec.target  = events.msg_target;
        unique case (events.operation)
            OPC_RECV_REQ: dec.op = OP_REQ;
            OPC_RECV_ACK: dec.op = OP_ACK;
            OPC_RECV_REL: dec.op = OP_REL;
            OPC_LOCAL:    dec.op = OP_LOCAL;
            OPC_TRY:      dec.op = OP_TRY;
            default:      dec.op = OP_NOP;
        endcase
    end

    assign events.ready = (cnt_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign push         = events.valid && events.ready;
    assign cmd_valid    = (cnt_reg != '0);
    assign cmd          = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

FILE: sv/lmx_back.sv
// Back end: clock, ack count, sorted request queue and result register.
module lmx_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lmx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lmx_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             cmd_valid,
    input  lmx_pkg::cmd_t                    cmd,
    output logic                             cmd_pop,
    output lmx_pkg::bstat_t                  bstat,
    lmx_result_if.source                     results
);
    import lmx_pkg::*;

    function automatic logic [CLOCK_W-1:0] sat_inc(input logic [CLOCK_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic key_before(input logic [CLOCK_W-1:0] c1,
                                        input logic [PROC_W-1:0]  p1,
                                        input logic [CLOCK_W-1:0] c2,
                                        input logic [PROC_W-1:0]  p2);
        key_before = (c1 != c2) ? (c1 < c2) : (p1 < p2);
    endfunction

    bstate_t             state_reg, state_next;
    logic [CLOCK_W-1:0]  clock_reg, clock_next;
    logic [7:0]          ack_reg, ack_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;
    logic [Q_CNT_W-1:0]  pos_reg, pos_next;
    logic [7:0]          own_id_reg, ack_needed_reg;

    logic [CLOCK_W-1:0]  ins_clock_reg, ins_clock_next;
    logic [PROC_W-1:0]   ins_proc_reg, ins_proc_next;
    logic [CLOCK_W-1:0]  head_clock_reg;
    logic [PROC_W-1:0]   head_proc_reg;

    kind_t               pend_kind_reg, pend_kind_next;
    logic [CLOCK_W-1:0]  pend_clock_reg, pend_clock_next;
    logic [PROC_W-1:0]   pend_proc_reg, pend_proc_next;
    logic [PROC_W-1:0]   pend_target_reg, pend_target_next;
    logic                pend_granted_reg, pend_granted_next;
    logic                pend_dropped_reg, pend_dropped_next;

    logic                res_valid_reg, res_valid_next;
    logic                res_load;
    kind_t               res_kind_reg;
    logic [CLOCK_W-1:0]  res_clock_reg, res_now_reg;
    logic [PROC_W-1:0]   res_proc_reg, res_target_reg;
    logic                res_granted_reg, res_dropped_reg;

    logic                ram_we;
    logic [Q_IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [CLOCK_W-1:0]  rd_clock, clk_rx;
    logic [PROC_W-1:0]   rd_proc;
    logic [Q_CNT_W-1:0]  pos_m1;
    logic                use_head;

    lmx_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_clock = ram_rdata[ENTRY_W-1:PROC_W];
    assign rd_proc  = ram_rdata[PROC_W-1:0];
    assign pos_m1   = pos_reg - Q_CNT_W'(1);
    assign clk_rx   = sat_inc((clock_reg > cmd.clock) ? clock_reg : cmd.clock);
    assign res_load = (state_reg == B_DONE) && (!res_valid_reg || results.ready);
    assign use_head = (pend_kind_reg == KIND_ACK) || (pend_kind_reg == KIND_REL);

    always_comb
    begin
        state_next        = state_reg;
        clock_next        = clock_reg;
        ack_next          = ack_reg;
        count_next        = count_reg;
        pos_next          = pos_reg;
        ins_clock_next    = ins_clock_reg;
        ins_proc_next     = ins_proc_reg;
        pend_kind_next    = pend_kind_reg;
        pend_clock_next   = pend_clock_reg;
        pend_proc_next    = pend_proc_reg;
        pend_target_next  = pend_target_reg;
        pend_granted_next = pend_granted_reg;
        pend_dropped_next = pend_dropped_reg;
        cmd_pop           = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = pos_reg[Q_IDX_W-1:0];
        ram_wdata         = {ins_clock_reg, ins_proc_reg};
        ram_raddr         = pos_m1[Q_IDX_W-1:0];

        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop           = 1'b1;
                    state_next        = B_DONE;
                    pend_kind_next    = KIND_NONE;
                    pend_clock_next   = '0;
                    pend_proc_next    = '0;
                    pend_target_next  = '0;
                    pend_granted_next = 1'b0;
                    pend_dropped_next = 1'b0;
                    unique case (cmd.op)
                        OP_REQ:
                        begin
                            if (count_reg < Q_CNT_W'(QUEUE_DEPTH))
                            begin
                                clock_next       = sat_inc(clk_rx);
                                ins_clock_next   = clk_rx;
                                ins_proc_next    = cmd.process;
                                pos_next         = count_reg;
                                pend_kind_next   = KIND_ACK;
                                pend_target_next = cmd.process;
                                state_next       = B_INS_RD;
                            end
                            else
                            begin
                                clock_next        = clk_rx;
                                pend_dropped_next = 1'b1;
                            end
                        end
                        OP_ACK:
                        begin
                            clock_next = clk_rx;
                            if (cmd.target == own_id_reg && ack_reg != 8'hFF)
                            begin
                                ack_next = ack_reg + 1'b1;
                            end
                        end
                        OP_REL:
                        begin
                            clock_next = clk_rx;
                            if (count_reg != '0 && head_proc_reg == cmd.target)
                            begin
                                pos_next   = Q_CNT_W'(1);
                                state_next = B_POP_RD;
                            end
                        end
                        OP_LOCAL:
                        begin
                            clock_next      = sat_inc(clock_reg);
                            pend_kind_next  = KIND_REQ;
                            pend_clock_next = sat_inc(clock_reg);
                            pend_proc_next  = own_id_reg;
                        end
                        OP_TRY:
                        begin
                            if (count_reg != '0 && head_proc_reg == own_id_reg &&
                                ack_reg == ack_needed_reg)
                            begin
                                ack_next          = '0;
                                clock_next        = sat_inc(clock_reg);
                                pend_kind_next    = KIND_REL;
                                pend_target_next  = own_id_reg;
                                pend_granted_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_INS_RD:
            begin
                // read the entry just below the insert position
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_INS_CMP;
                end
            end
            B_INS_CMP:
            begin
                ram_we = 1'b1;
                if (key_before(ins_clock_reg, ins_proc_reg, rd_clock, rd_proc))
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = pos_m1;
                    state_next = B_INS_RD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = B_DONE;
                end
            end
            B_POP_RD:
            begin
                ram_raddr = pos_reg[Q_IDX_W-1:0];
                if (pos_reg == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_POP_WR;
                end
            end
            B_POP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_m1[Q_IDX_W-1:0];
                ram_wdata  = ram_rdata;
                pos_next   = pos_reg + 1'b1;
                state_next = B_POP_RD;
            end
            B_DONE:
            begin
                if (res_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign bstat.busy  = (state_reg != B_IDLE);
    assign bstat.count = count_reg;

    assign results.valid       = res_valid_reg;
    assign results.out_kind    = res_kind_reg;
    assign results.out_clock   = res_clock_reg;
    assign results.out_process = res_proc_reg;
    assign results.out_target  = res_target_reg;
    assign results.granted     = res_granted_reg;
    assign results.dropped     = res_dropped_reg;
    assign results.clock_now   = res_now_reg;

    // payload registers
    always_ff @(posedge clk)
    begin
        ins_clock_reg    <= ins_clock_next;
        ins_proc_reg     <= ins_proc_next;
        pos_reg          <= pos_next;
        pend_kind_reg    <= pend_kind_next;
        pend_clock_reg   <= pend_clock_next;
        pend_proc_reg    <= pend_proc_next;
        pend_target_reg  <= pend_target_next;
        pend_granted_reg <= pend_granted_next;
        pend_dropped_reg <= pend_dropped_next;
        // head copy tracks every write to entry zero
        if (ram_we && ram_waddr == '0)
        begin
            head_clock_reg <= ram_wdata[ENTRY_W-1:PROC_W];
            head_proc_reg  <= ram_wdata[PROC_W-1:0];
        end
        if (res_load)
        begin
            res_kind_reg    <= pend_kind_reg;
            res_clock_reg   <= use_head ? head_clock_reg : pend_clock_reg;
            res_proc_reg    <= use_head ? head_proc_reg : pend_proc_reg;
            res_target_reg  <= pend_target_reg;
            res_granted_reg <= pend_granted_reg;
            res_dropped_reg <= pend_dropped_reg;
            res_now_reg     <= clock_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            clock_reg      <= '0;
            ack_reg        <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
            own_id_reg     <= 8'd0;
            ack_needed_reg <= 8'd1;
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            ack_reg       <= ack_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we && cfg_index == REG_OWN_ID)
            begin
                own_id_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_ACK_NEEDED)
            begin
                ack_needed_reg <= cfg_data;
            end
        end
    end
endmodule

FILE: sv/lamport_mutex_node_unit.sv
// Top level: one node of Lamport mutual exclusion.
// Flow: an event is queued in the front end; the back end pops it when idle, updates its state
// and loads the result register. A queued REQ first walks the sorted queue, moving each entry
// that sorts after it up (B_INS_RD, B_INS_CMP); a REL that pops shifts the rest down
// (B_POP_RD, B_POP_WR), both over the registered RAM read. The back end takes a new command
// only when idle, after its result is loaded; the 2-entry front queue absorbs a busy back end.
// Reset: clock, ack count and fill count clear, own_id 0, ack_needed 1; queue RAM not cleared.
module lamport_mutex_node_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lmx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmx_pkg::CFG_DATA_W-1:0] cfg_data,
    lmx_event_if.sink                      events,
    lmx_result_if.source                   results
);
    import lmx_pkg::*;

    logic   cmd_valid;
    logic   cmd_pop;
    cmd_t   cmd;
    bstat_t bstat;

    lmx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .events    (events),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    lmx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .bstat     (bstat),
        .results   (results)
    );

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !bstat.busy)
        else $error("command popped while back end busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.count <= Q_CNT_W'(QUEUE_DEPTH))
        else $error("request queue overfilled");

    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.dropped) |->
            (results.out_kind == KIND_NONE && !results.granted))
        else $error("dropped request produced a message");
endmodule
